>>> hdl/cpru_pkg.sv
// ----------------------------------------------------------------------------
// cpru_pkg: shared types and arithmetic helpers for the camera pose updater
// Payload structs, command encoding and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package cpru_pkg;

    localparam int DATA_W  = 32;
    localparam int Q_DEPTH = 2;

    // action codes of the input item
    localparam logic [3:0] ACT_LOAD_POS   = 4'd0;
    localparam logic [3:0] ACT_LOAD_FWD   = 4'd1;
    localparam logic [3:0] ACT_LOAD_UP    = 4'd2;
    localparam logic [3:0] ACT_FWD        = 4'd3;
    localparam logic [3:0] ACT_BACK       = 4'd4;
    localparam logic [3:0] ACT_TURN_UP    = 4'd5;
    localparam logic [3:0] ACT_TURN_DOWN  = 4'd6;
    localparam logic [3:0] ACT_TURN_LEFT  = 4'd7;
    localparam logic [3:0] ACT_TURN_RIGHT = 4'd8;
    localparam logic [3:0] ACT_TILT_LEFT  = 4'd9;
    localparam logic [3:0] ACT_TILT_RIGHT = 4'd10;

    // configuration register indexes
    localparam logic [2:0] CFG_MOVE_STEP  = 3'd0;
    localparam logic [2:0] CFG_SIN_STEP   = 3'd1;
    localparam logic [2:0] CFG_OMC_STEP   = 3'd2;
    localparam logic [2:0] CFG_PLANE_W    = 3'd3;
    localparam logic [2:0] CFG_FOCAL      = 3'd4;

    // reported vector kinds
    localparam logic [2:0] KIND_POS = 3'd0;
    localparam logic [2:0] KIND_FWD = 3'd1;
    localparam logic [2:0] KIND_UP  = 3'd2;
    localparam logic [2:0] KIND_RGT = 3'd3;
    localparam logic [2:0] KIND_EYE = 3'd4;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         vector_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_LOAD_POS,
        OP_LOAD_FWD,
        OP_LOAD_UP,
        OP_MOVE,
        OP_ROT,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        AX_RIGHT,
        AX_UP,
        AX_FWD
    } axis_t;

    typedef logic [2:0][DATA_W-1:0] vec_t;

    typedef struct packed {
        op_t   op;
        axis_t axis;
        logic  neg;
        vec_t  vec;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [32:0] sext33(input logic [31:0] a);
        return {a[31], a};
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic logic [31:0] sat66(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31])
            r = s[32] ? 32'h80000000 : 32'h7fffffff;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
        return sat33({a[31], a} - {b[31], b});
    endfunction

endpackage

>>> hdl/camera_pose_rotation_update_top.sv
// Each command runs to completion in the engine and then reports five results;
// the next command starts only after that. The bit-pair square root and the
// restoring divider dominate the run time of load and turn commands.
// Results leave at one per cycle while the output side takes them.
// Reset (rst_n, asynchronous, active low) restores the default pose and registers.
// ----------------------------------------------------------------------------
// camera_pose_rotation_update_top: camera pose keeper with fixed-step rotation
// Intake classifies commands into a queue; the execution engine updates the
// pose and reports position, forward, up, right and the eye point.
// ----------------------------------------------------------------------------
module camera_pose_rotation_update_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [30:0]         cfg_data,
    // command channel: transfer when in_valid and not in_stall
    input  logic                in_valid,
    output logic                in_stall,
    input  cpru_pkg::in_item_t  in_data,
    // result channel: transfer when out_valid and not out_stall
    output logic                out_valid,
    input  logic                out_stall,
    output cpru_pkg::out_item_t out_data
);

    cpru_pkg::q_stat_t q_stat;
    cpru_pkg::cmd_t    push_cmd;
    cpru_pkg::cmd_t    head;
    logic              push;
    logic              pop;

    // intake: classify the action and push into the queue; stall when full
    cpru_front u_front (
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // queue lets intake keep taking commands while the engine works
    cpru_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // engine: one shared multiplier, square root and divider, output register
    cpru_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hdl/cpru_front.sv
// ----------------------------------------------------------------------------
// cpru_front: command intake
// Accepts input items and classifies the action into a queued command.
// ----------------------------------------------------------------------------
module cpru_front (
    input  logic                in_valid,
    input  cpru_pkg::in_item_t  in_data,
    output logic                in_stall,
    input  cpru_pkg::q_stat_t   q_stat,
    output logic                push,
    output cpru_pkg::cmd_t      push_cmd
);

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        push_cmd.vec  = {in_data.load_z, in_data.load_y, in_data.load_x};
        push_cmd.op   = cpru_pkg::OP_NOP;
        push_cmd.axis = cpru_pkg::AX_RIGHT;
        push_cmd.neg  = 1'b0;
        unique case (in_data.action)
            cpru_pkg::ACT_LOAD_POS: push_cmd.op = cpru_pkg::OP_LOAD_POS;
            cpru_pkg::ACT_LOAD_FWD: push_cmd.op = cpru_pkg::OP_LOAD_FWD;
            cpru_pkg::ACT_LOAD_UP:  push_cmd.op = cpru_pkg::OP_LOAD_UP;
            cpru_pkg::ACT_FWD:      push_cmd.op = cpru_pkg::OP_MOVE;
            cpru_pkg::ACT_BACK:
            begin
                push_cmd.op  = cpru_pkg::OP_MOVE;
                push_cmd.neg = 1'b1;
            end
            cpru_pkg::ACT_TURN_UP:
            begin
                push_cmd.op = cpru_pkg::OP_ROT;
            end
            cpru_pkg::ACT_TURN_DOWN:
            begin
                push_cmd.op  = cpru_pkg::OP_ROT;
                push_cmd.neg = 1'b1;
            end
            cpru_pkg::ACT_TURN_LEFT:
            begin
                push_cmd.op   = cpru_pkg::OP_ROT;
                push_cmd.axis = cpru_pkg::AX_UP;
            end
            cpru_pkg::ACT_TURN_RIGHT:
            begin
                push_cmd.op   = cpru_pkg::OP_ROT;
                push_cmd.axis = cpru_pkg::AX_UP;
                push_cmd.neg  = 1'b1;
            end
            cpru_pkg::ACT_TILT_LEFT:
            begin
                push_cmd.op   = cpru_pkg::OP_ROT;
                push_cmd.axis = cpru_pkg::AX_FWD;
                push_cmd.neg  = 1'b1;
            end
            cpru_pkg::ACT_TILT_RIGHT:
            begin
                push_cmd.op   = cpru_pkg::OP_ROT;
                push_cmd.axis = cpru_pkg::AX_FWD;
            end
            default: push_cmd.op = cpru_pkg::OP_NOP;
        endcase
    end

endmodule

>>> hdl/cpru_queue.sv
// ----------------------------------------------------------------------------
// cpru_queue: command queue
// Small first-in first-out buffer between intake and execution.
// ----------------------------------------------------------------------------
module cpru_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cpru_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output cpru_pkg::cmd_t    head,
    output cpru_pkg::q_stat_t q_stat
);

    localparam int PTR_W = $clog2(cpru_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(cpru_pkg::Q_DEPTH + 1);

    cpru_pkg::cmd_t   mem_reg [cpru_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(cpru_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(cpru_pkg::Q_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(cpru_pkg::Q_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> hdl/cpru_back.sv
// ----------------------------------------------------------------------------
// cpru_back: pose execution engine
// Sequences loads, moves, rotations and renormalization over one shared
// multiplier, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
module cpru_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [30:0]         cfg_data,
    input  cpru_pkg::cmd_t      head,
    input  cpru_pkg::q_stat_t   q_stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output cpru_pkg::out_item_t out_data
);

    localparam int DIV_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [31:0] ONE     = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] NEG_ONE = ~ONE + 32'd1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CROSS = 10'b0000000010,
        ST_COMB  = 10'b0000000100,
        ST_SQ    = 10'b0000001000,
        ST_SQRT  = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_NDONE = 10'b0001000000,
        ST_MOVE  = 10'b0010000000,
        ST_EYE   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        CR_W,
        CR_W2,
        CR_R
    } cross_t;

    state_t             state_reg;
    cross_t             cross_sel_reg;
    logic               pass_reg;
    logic               dload_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [1:0]         k_reg;
    logic [2:0]         kind_reg;

    logic [30:0]        move_step_reg;
    logic [16:0]        sin_step_reg;
    logic [17:0]        omc_step_reg;
    logic [30:0]        plane_w_reg;
    logic [30:0]        focal_reg;

    cpru_pkg::vec_t     pos_reg, fwd_reg, up_reg, rgt_reg;
    cpru_pkg::vec_t     xa_reg, xb_reg, xw_reg, xw2_reg, xv_reg, xorig_reg, res0_reg;
    cpru_pkg::cmd_t     cmd_reg;

    logic signed [65:0] prod_reg;
    logic [31:0]        t1_reg;
    logic [31:0]        dist_reg;
    logic [63:0]        sum_reg, rem_reg, root_reg, bit_reg;
    logic [DIV_W-1:0]   dq_reg;
    logic [31:0]        drem_reg;

    logic               out_valid_reg;
    cpru_pkg::out_item_t out_data_reg;

    logic [2:0]         mi;
    logic               ph;
    logic [1:0]         ck, k1, k2, ai, bi, ek;
    cpru_pkg::vec_t     bsrc;
    logic signed [32:0] ma, mb;
    logic signed [17:0] s18;
    logic [31:0]        fm;
    logic [63:0]        sq_sum;
    logic [63:0]        trial;
    logic [32:0]        dshift;
    logic               qbit;
    logic [DIV_W-1:0]   dq_step;
    logic [31:0]        quo;
    logic               out_load;
    cpru_pkg::vec_t     out_vec;
    cpru_pkg::vec_t     rot_q;

    assign mi  = cnt_reg[3:1];
    assign ph  = cnt_reg[0];
    assign pop = (state_reg == ST_IDLE) && !q_stat.empty;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // operand selection for the shared multiplier
    always_comb
    begin
        ck = mi[2:1];
        case (ck)
            2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
            2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
            default: begin k1 = 2'd0; k2 = 2'd1; end
        endcase
        ai   = mi[0] ? k2 : k1;
        bi   = mi[0] ? k1 : k2;
        ek   = mi[1:0] - 2'd1;
        bsrc = (cross_sel_reg == CR_W2) ? xw_reg : xb_reg;
        s18  = cmd_reg.neg ? -$signed({1'b0, sin_step_reg}) : $signed({1'b0, sin_step_reg});
        ma   = '0;
        mb   = '0;
        unique case (state_reg)
            ST_CROSS:
            begin
                ma = cpru_pkg::sext33(xa_reg[ai]);
                mb = cpru_pkg::sext33(bsrc[bi]);
            end
            ST_COMB:
            begin
                if (mi[0])
                begin
                    ma = {15'd0, omc_step_reg};
                    mb = cpru_pkg::sext33(xw2_reg[ck]);
                end
                else
                begin
                    ma = {{15{s18[17]}}, s18};
                    mb = cpru_pkg::sext33(xw_reg[ck]);
                end
            end
            ST_SQ:
            begin
                ma = {1'b0, cpru_pkg::mag(xv_reg[mi[1:0]])};
                mb = {1'b0, cpru_pkg::mag(xv_reg[mi[1:0]])};
            end
            ST_MOVE:
            begin
                ma = cpru_pkg::sext33(fwd_reg[mi[1:0]]);
                mb = {2'd0, move_step_reg};
            end
            ST_EYE:
            begin
                if (mi == 3'd0)
                begin
                    ma = {2'd0, plane_w_reg};
                    mb = {2'd0, focal_reg};
                end
                else
                begin
                    ma = cpru_pkg::sext33(fwd_reg[ek]);
                    mb = cpru_pkg::sext33(dist_reg);
                end
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        fm      = cpru_pkg::sat66(prod_reg >>> FRAC_BITS);
        sq_sum  = sum_reg + prod_reg[63:0];
        trial   = root_reg + bit_reg;
        dshift  = {drem_reg, dq_reg[DIV_W-1]};
        qbit    = (dshift >= {1'b0, root_reg[31:0]});
        dq_step = {dq_reg[DIV_W-2:0], qbit};
        quo     = dq_step[31:0];
        case (cmd_reg.axis)
            cpru_pkg::AX_RIGHT: rot_q = up_reg;
            cpru_pkg::AX_UP:    rot_q = fwd_reg;
            default:            rot_q = rgt_reg;
        endcase
        case (kind_reg)
            cpru_pkg::KIND_POS: out_vec = pos_reg;
            cpru_pkg::KIND_FWD: out_vec = fwd_reg;
            cpru_pkg::KIND_UP:  out_vec = up_reg;
            cpru_pkg::KIND_RGT: out_vec = rgt_reg;
            default:            out_vec = xw_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cross_sel_reg <= CR_W;
            pass_reg      <= 1'b0;
            dload_reg     <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            kind_reg      <= cpru_pkg::KIND_POS;
            move_step_reg <= 31'd6554;
            sin_step_reg  <= 17'd1144;
            omc_step_reg  <= 18'd10;
            plane_w_reg   <= 31'd131072;
            focal_reg     <= 31'd32768;
            pos_reg       <= '0;
            fwd_reg       <= {ONE, 32'd0, 32'd0};
            up_reg        <= {32'd0, ONE, 32'd0};
            rgt_reg       <= {32'd0, 32'd0, NEG_ONE};
            xa_reg        <= '0;
            xb_reg        <= '0;
            xw_reg        <= '0;
            xw2_reg       <= '0;
            xv_reg        <= '0;
            xorig_reg     <= '0;
            res0_reg      <= '0;
            cmd_reg       <= '0;
            t1_reg        <= '0;
            dist_reg      <= '0;
            sum_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            dq_reg        <= '0;
            drem_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    cpru_pkg::CFG_MOVE_STEP: move_step_reg <= cfg_data;
                    cpru_pkg::CFG_SIN_STEP:  sin_step_reg  <= cfg_data[16:0];
                    cpru_pkg::CFG_OMC_STEP:  omc_step_reg  <= cfg_data[17:0];
                    cpru_pkg::CFG_PLANE_W:   plane_w_reg   <= cfg_data;
                    cpru_pkg::CFG_FOCAL:     focal_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // output register: drop on transfer, load new results
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= '{vector_kind: kind_reg,
                                   out_x: out_vec[0],
                                   out_y: out_vec[1],
                                   out_z: out_vec[2],
                                   last_of_run: (kind_reg == cpru_pkg::KIND_EYE)};
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    if (pop)
                    begin
                        cmd_reg <= head;
                        case (head.op)
                            cpru_pkg::OP_LOAD_POS:
                            begin
                                pos_reg   <= head.vec;
                                state_reg <= ST_EYE;
                            end
                            cpru_pkg::OP_LOAD_FWD, cpru_pkg::OP_LOAD_UP:
                            begin
                                xv_reg    <= head.vec;
                                state_reg <= ST_SQ;
                            end
                            cpru_pkg::OP_MOVE:
                            begin
                                state_reg <= ST_MOVE;
                            end
                            cpru_pkg::OP_ROT:
                            begin
                                pass_reg      <= 1'b0;
                                cross_sel_reg <= CR_W;
                                state_reg     <= ST_CROSS;
                                case (head.axis)
                                    cpru_pkg::AX_RIGHT:
                                    begin
                                        xa_reg    <= rgt_reg;
                                        xb_reg    <= fwd_reg;
                                        xorig_reg <= fwd_reg;
                                    end
                                    cpru_pkg::AX_UP:
                                    begin
                                        xa_reg    <= up_reg;
                                        xb_reg    <= rgt_reg;
                                        xorig_reg <= rgt_reg;
                                    end
                                    default:
                                    begin
                                        xa_reg    <= fwd_reg;
                                        xb_reg    <= up_reg;
                                        xorig_reg <= up_reg;
                                    end
                                endcase
                            end
                            default:
                            begin
                                state_reg <= ST_EYE;
                            end
                        endcase
                    end
                end

                ST_CROSS:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (ph)
                    begin
                        if (!mi[0])
                            t1_reg <= fm;
                        else
                        begin
                            case (cross_sel_reg)
                                CR_W:    xw_reg[ck]  <= cpru_pkg::fsub(t1_reg, fm);
                                CR_W2:   xw2_reg[ck] <= cpru_pkg::fsub(t1_reg, fm);
                                default: rgt_reg[ck] <= cpru_pkg::fsub(t1_reg, fm);
                            endcase
                        end
                        if (mi == 3'd5)
                        begin
                            cnt_reg <= '0;
                            case (cross_sel_reg)
                                CR_W:    cross_sel_reg <= CR_W2;
                                CR_W2:   state_reg     <= ST_COMB;
                                default: state_reg     <= ST_EYE;
                            endcase
                        end
                    end
                end

                ST_COMB:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (ph)
                    begin
                        if (!mi[0])
                            t1_reg <= cpru_pkg::fadd(xorig_reg[ck], fm);
                        else
                            xv_reg[ck] <= cpru_pkg::fadd(t1_reg, fm);
                        if (mi == 3'd5)
                        begin
                            cnt_reg   <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_SQ;
                        end
                    end
                end

                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (ph)
                    begin
                        sum_reg <= sq_sum;
                        if (mi == 3'd2)
                        begin
                            cnt_reg  <= '0;
                            rem_reg  <= sq_sum;
                            root_reg <= '0;
                            bit_reg  <= 64'd1 << 62;
                            // a zero-length vector stays as it is
                            state_reg <= (sq_sum == '0) ? ST_NDONE : ST_SQRT;
                        end
                    end
                end

                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == CNT_W'(31))
                    begin
                        cnt_reg   <= '0;
                        k_reg     <= '0;
                        dload_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (dload_reg)
                    begin
                        dq_reg    <= {cpru_pkg::mag(xv_reg[k_reg]), {FRAC_BITS{1'b0}}};
                        drem_reg  <= '0;
                        dload_reg <= 1'b0;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                        dq_reg   <= dq_step;
                        drem_reg <= qbit ? 32'(dshift - {1'b0, root_reg[31:0]})
                                         : dshift[31:0];
                        if (cnt_reg == CNT_W'(DIV_W - 1))
                        begin
                            xv_reg[k_reg] <= xv_reg[k_reg][31] ? (~quo + 32'd1) : quo;
                            cnt_reg       <= '0;
                            if (k_reg == 2'd2)
                                state_reg <= ST_NDONE;
                            else
                            begin
                                k_reg     <= k_reg + 2'd1;
                                dload_reg <= 1'b1;
                            end
                        end
                    end
                end

                ST_NDONE:
                begin
                    cnt_reg <= '0;
                    case (cmd_reg.op)
                        cpru_pkg::OP_LOAD_FWD:
                        begin
                            fwd_reg       <= xv_reg;
                            xa_reg        <= xv_reg;
                            xb_reg        <= up_reg;
                            cross_sel_reg <= CR_R;
                            state_reg     <= ST_CROSS;
                        end
                        cpru_pkg::OP_LOAD_UP:
                        begin
                            up_reg        <= xv_reg;
                            xa_reg        <= fwd_reg;
                            xb_reg        <= xv_reg;
                            cross_sel_reg <= CR_R;
                            state_reg     <= ST_CROSS;
                        end
                        cpru_pkg::OP_ROT:
                        begin
                            if (!pass_reg)
                            begin
                                // first vector done; rotate the second one
                                res0_reg      <= xv_reg;
                                pass_reg      <= 1'b1;
                                xb_reg        <= rot_q;
                                xorig_reg     <= rot_q;
                                cross_sel_reg <= CR_W;
                                state_reg     <= ST_CROSS;
                            end
                            else
                            begin
                                case (cmd_reg.axis)
                                    cpru_pkg::AX_RIGHT:
                                    begin
                                        fwd_reg <= res0_reg;
                                        up_reg  <= xv_reg;
                                    end
                                    cpru_pkg::AX_UP:
                                    begin
                                        rgt_reg <= res0_reg;
                                        fwd_reg <= xv_reg;
                                    end
                                    default:
                                    begin
                                        up_reg  <= res0_reg;
                                        rgt_reg <= xv_reg;
                                    end
                                endcase
                                state_reg <= ST_EYE;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_EYE;
                        end
                    endcase
                end

                ST_MOVE:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (ph)
                    begin
                        pos_reg[mi[1:0]] <= cmd_reg.neg ? cpru_pkg::fsub(pos_reg[mi[1:0]], fm)
                                                        : cpru_pkg::fadd(pos_reg[mi[1:0]], fm);
                        if (mi == 3'd2)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_EYE;
                        end
                    end
                end

                ST_EYE:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (ph)
                    begin
                        if (mi == 3'd0)
                            dist_reg <= fm;
                        else
                            xw_reg[ek] <= cpru_pkg::fsub(pos_reg[ek], fm);
                        if (mi == 3'd3)
                        begin
                            cnt_reg   <= '0;
                            kind_reg  <= cpru_pkg::KIND_POS;
                            state_reg <= ST_OUT;
                        end
                    end
                end

                ST_OUT:
                begin
                    if (out_load)
                    begin
                        kind_reg <= kind_reg + 3'd1;
                        if (kind_reg == cpru_pkg::KIND_EYE)
                            state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // last flag marks exactly the eye point result
    a_last_on_eye: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_of_run == (out_data.vector_kind == cpru_pkg::KIND_EYE)))
        else $error("last_of_run does not match the eye point result");

    // the divider only runs on a nonzero length that fits 32 bits
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (root_reg[63:32] == '0 && root_reg[31:0] != '0))
        else $error("square root out of range at division");

    // the eye point result closes the run and frees the sequencer
    a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && kind_reg == cpru_pkg::KIND_EYE) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the run");

endmodule

>>> test/tb_camera_pose_rotation_update_top.sv
// ----------------------------------------------------------------------------
// tb_camera_pose_rotation_update_top: self-checking bench for the pose updater
// Walks a table of directed commands, then random commands under several
// register settings, and compares every result transfer with a local model.
// ----------------------------------------------------------------------------
module tb_camera_pose_rotation_update_top;

    localparam int  FRAC          = 16;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  RAND_PER_SET  = 48;
    localparam int  PRESSURE_HOLD = 3000;
    localparam logic [3:0] ACT_UNUSED_LO = 4'd11;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
    localparam logic [2:0] CFG_UNUSED    = 3'd5;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;

    typedef logic [2:0][63:0] v3_t;

    // one directed command; fx, fy and fz give the forward result when it is known by eye
    typedef struct {
        logic [3:0]         act;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 known;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [2:0]  cfg_idx;
    logic [30:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    cpru_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    cpru_pkg::out_item_t out_data;

    camera_pose_rotation_update_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // model copy of the pose and the registers
    v3_t    pose_pos, pose_fwd, pose_up, pose_rgt;
    longint reg_move, reg_sin, reg_omc, reg_pw, reg_ff;

    cpru_pkg::out_item_t pending_q[$];
    int        err_count;
    int        cycle_count;
    bit        quiet;
    int        hold_req;
    dir_row_t  dir_tab [22];

    // 12-unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // fixed-point arithmetic of the pose model
    // ------------------------------------------------------------------------
    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor of the product, then clamp
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return sat_q(p >>> FRAC);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return sat_q(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return sat_q(a - b);
    endfunction

    function automatic longint comp(v3_t v, int i);
        return $signed(v[i]);
    endfunction

    function automatic v3_t vcross(v3_t a, v3_t b);
        v3_t r;
        r[0] = qsub(qmul(comp(a, 1), comp(b, 2)), qmul(comp(a, 2), comp(b, 1)));
        r[1] = qsub(qmul(comp(a, 2), comp(b, 0)), qmul(comp(a, 0), comp(b, 2)));
        r[2] = qsub(qmul(comp(a, 0), comp(b, 1)), qmul(comp(a, 1), comp(b, 0)));
        return r;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale to unit length; a zero vector stays as it is
    function automatic v3_t unit_len(v3_t v);
        longint unsigned sq, len, m, q;
        longint c;
        v3_t r;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            c  = comp(v, i);
            m  = (c < 0) ? -c : c;
            sq = sq + m * m;
        end
        if (sq == 0)
            return v;
        len = root_floor(sq);
        for (int i = 0; i < 3; i++)
        begin
            c    = comp(v, i);
            m    = (c < 0) ? -c : c;
            q    = (m << FRAC) / len;
            r[i] = (c < 0) ? -longint'(q) : longint'(q);
        end
        return r;
    endfunction

    function automatic v3_t turn_vec(v3_t axis, v3_t v, longint s);
        v3_t w, w2, r;
        w  = vcross(axis, v);
        w2 = vcross(axis, w);
        for (int i = 0; i < 3; i++)
            r[i] = qadd(qadd(comp(v, i), qmul(s, comp(w, i))), qmul(reg_omc, comp(w2, i)));
        return unit_len(r);
    endfunction

    function automatic cpru_pkg::out_item_t make_result(logic [2:0] kind, v3_t v, logic last);
        cpru_pkg::out_item_t o;
        o.vector_kind = kind;
        o.out_x       = v[0][31:0];
        o.out_y       = v[1][31:0];
        o.out_z       = v[2][31:0];
        o.last_of_run = last;
        return o;
    endfunction

    // advance the model by one command and queue the five results it reports
    task automatic predict_pose(cpru_pkg::in_item_t it);
        v3_t    ld, eye, a, b;
        longint s, d, span;
        ld[0] = longint'(it.load_x);
        ld[1] = longint'(it.load_y);
        ld[2] = longint'(it.load_z);
        s = (it.action == cpru_pkg::ACT_TURN_DOWN || it.action == cpru_pkg::ACT_TURN_RIGHT ||
             it.action == cpru_pkg::ACT_TILT_LEFT) ? -reg_sin : reg_sin;
        case (it.action)
            cpru_pkg::ACT_LOAD_POS:
                pose_pos = ld;
            cpru_pkg::ACT_LOAD_FWD:
            begin
                pose_fwd = unit_len(ld);
                pose_rgt = vcross(pose_fwd, pose_up);
            end
            cpru_pkg::ACT_LOAD_UP:
            begin
                pose_up  = unit_len(ld);
                pose_rgt = vcross(pose_fwd, pose_up);
            end
            cpru_pkg::ACT_FWD, cpru_pkg::ACT_BACK:
                for (int i = 0; i < 3; i++)
                begin
                    d = qmul(comp(pose_fwd, i), reg_move);
                    pose_pos[i] = (it.action == cpru_pkg::ACT_FWD)
                                  ? qadd(comp(pose_pos, i), d)
                                  : qsub(comp(pose_pos, i), d);
                end
            cpru_pkg::ACT_TURN_UP, cpru_pkg::ACT_TURN_DOWN:
            begin
                a = turn_vec(pose_rgt, pose_fwd, s);
                b = turn_vec(pose_rgt, pose_up, s);
                pose_fwd = a;
                pose_up  = b;
            end
            cpru_pkg::ACT_TURN_LEFT, cpru_pkg::ACT_TURN_RIGHT:
            begin
                a = turn_vec(pose_up, pose_rgt, s);
                b = turn_vec(pose_up, pose_fwd, s);
                pose_rgt = a;
                pose_fwd = b;
            end
            cpru_pkg::ACT_TILT_LEFT, cpru_pkg::ACT_TILT_RIGHT:
            begin
                a = turn_vec(pose_fwd, pose_up, s);
                b = turn_vec(pose_fwd, pose_rgt, s);
                pose_up  = a;
                pose_rgt = b;
            end
            default:
                ;
        endcase
        span = qmul(reg_pw, reg_ff);
        for (int i = 0; i < 3; i++)
            eye[i] = qsub(comp(pose_pos, i), qmul(comp(pose_fwd, i), span));
        pending_q.push_back(make_result(cpru_pkg::KIND_POS, pose_pos, 1'b0));
        pending_q.push_back(make_result(cpru_pkg::KIND_FWD, pose_fwd, 1'b0));
        pending_q.push_back(make_result(cpru_pkg::KIND_UP,  pose_up,  1'b0));
        pending_q.push_back(make_result(cpru_pkg::KIND_RGT, pose_rgt, 1'b0));
        pending_q.push_back(make_result(cpru_pkg::KIND_EYE, eye,      1'b1));
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 262144)) - 32'sd131072;
            2: return 32'sd0;
            default:
                case ($urandom_range(3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return Q_ONE;
                    default: return -Q_ONE;
                endcase
        endcase
    endfunction

    // mostly valid commands with loads and turns mixed in, a few unused codes
    function automatic cpru_pkg::in_item_t rand_cmd();
        cpru_pkg::in_item_t it;
        if ($urandom_range(99) < 5)
            it.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        else
            it.action = 4'($urandom_range(cpru_pkg::ACT_LOAD_POS, cpru_pkg::ACT_TILT_RIGHT));
        it.load_x = rand_comp();
        it.load_y = rand_comp();
        it.load_z = rand_comp();
        return it;
    endfunction

    // offer one command, hold it until the transfer, then predict its results
    task automatic send_cmd(cpru_pkg::in_item_t it, bit known, v3_t known_fwd);
        int gap;
        if (!quiet && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_pose(it);
        // typed-in forward result replaces the modeled one
        if (known)
        begin
            pending_q[pending_q.size() - 4].out_x = known_fwd[0][31:0];
            pending_q[pending_q.size() - 4].out_y = known_fwd[1][31:0];
            pending_q[pending_q.size() - 4].out_z = known_fwd[2][31:0];
        end
    endtask

    // drop the command valid, drain every result and let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // write the register set; valid only when the block is idle
    task automatic set_regs(longint mv, longint sn, longint omc, longint pw, longint ff);
        logic [30:0] vals [5];
        logic [30:0] junk;
        vals[0] = 31'(mv);
        vals[1] = 31'(sn);
        vals[2] = 31'(omc);
        vals[3] = 31'(pw);
        vals[4] = 31'(ff);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_idx  <= cpru_pkg::CFG_MOVE_STEP + 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        reg_move = vals[0];
        reg_sin  = vals[1] & 31'h1ffff;
        reg_omc  = vals[2] & 31'h3ffff;
        reg_pw   = vals[3];
        reg_ff   = vals[4];
        // an index past the list must leave everything alone
        junk = 31'($urandom);
        cfg_idx  <= 3'($urandom_range(CFG_UNUSED, 7));
        cfg_data <= junk;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_set(int n);
        v3_t none;
        none = '0;
        for (int i = 0; i < n; i++)
            send_cmd(rand_cmd(), 1'b0, none);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // result side: check each transfer and shape the stall pattern
    // ------------------------------------------------------------------------
    int stall_left;
    int hold_left;

    always @(posedge clk)
    begin
        cpru_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result transfer with nothing pending: kind %0d", out_data.vector_kind);
                err_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (out_data.vector_kind !== want.vector_kind)
                begin
                    $error("vector_kind: expected %0d, got %0d", want.vector_kind,
                           out_data.vector_kind);
                    err_count++;
                end
                if (out_data.out_x !== want.out_x)
                begin
                    $error("out_x: expected %0d, got %0d", want.out_x, out_data.out_x);
                    err_count++;
                end
                if (out_data.out_y !== want.out_y)
                begin
                    $error("out_y: expected %0d, got %0d", want.out_y, out_data.out_y);
                    err_count++;
                end
                if (out_data.out_z !== want.out_z)
                begin
                    $error("out_z: expected %0d, got %0d", want.out_z, out_data.out_z);
                    err_count++;
                end
                if (out_data.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           out_data.last_of_run);
                    err_count++;
                end
            end
        end
        // long hold-off first, then short random bursts
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        v3_t kf;
        cpru_pkg::in_item_t it;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        hold_req    = 0;
        stall_left  = 0;
        hold_left   = 0;

        // model state after reset
        pose_pos = '0;
        pose_fwd = '0;
        pose_up  = '0;
        pose_rgt = '0;
        pose_fwd[2] = 64'(Q_ONE);
        pose_up[1]  = 64'(Q_ONE);
        pose_rgt[0] = -64'sd65536;
        reg_move = 6554;
        reg_sin  = 1144;
        reg_omc  = 10;
        reg_pw   = 131072;
        reg_ff   = 32768;

        // unused code right after reset reports the default pose
        dir_tab[0]  = '{ACT_UNUSED_HI, 0, 0, 0, 1, 0, 0, Q_ONE};
        // position extremes, moves saturate
        dir_tab[1]  = '{cpru_pkg::ACT_LOAD_POS, S_MAX, S_MAX, S_MAX, 0, 0, 0, 0};
        dir_tab[2]  = '{cpru_pkg::ACT_FWD, 0, 0, 0, 1, 0, 0, Q_ONE};
        dir_tab[3]  = '{cpru_pkg::ACT_LOAD_POS, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0};
        dir_tab[4]  = '{cpru_pkg::ACT_BACK, -1, -1, -1, 1, 0, 0, Q_ONE};
        // zero-length forward load stores the zero vector as forward
        dir_tab[5]  = '{cpru_pkg::ACT_LOAD_FWD, 0, 0, 0, 1, 0, 0, 0};
        dir_tab[6]  = '{cpru_pkg::ACT_LOAD_FWD, 7, 0, 0, 1, Q_ONE, 0, 0};
        dir_tab[7]  = '{cpru_pkg::ACT_LOAD_FWD, S_MIN, 0, 0, 1, -Q_ONE, 0, 0};
        dir_tab[8]  = '{cpru_pkg::ACT_LOAD_FWD, S_MAX, S_MAX, S_MAX, 0, 0, 0, 0};
        dir_tab[9]  = '{cpru_pkg::ACT_LOAD_UP, S_MIN, S_MAX, S_MIN, 0, 0, 0, 0};
        dir_tab[10] = '{cpru_pkg::ACT_LOAD_UP, 0, Q_ONE, 0, 0, 0, 0, 0};
        dir_tab[11] = '{cpru_pkg::ACT_LOAD_FWD, 0, 0, 3, 1, 0, 0, Q_ONE};
        dir_tab[12] = '{cpru_pkg::ACT_LOAD_POS, 100000, -3, 5, 1, 0, 0, Q_ONE};
        dir_tab[13] = '{cpru_pkg::ACT_TURN_UP, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[14] = '{cpru_pkg::ACT_TURN_DOWN, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[15] = '{cpru_pkg::ACT_TURN_LEFT, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[16] = '{cpru_pkg::ACT_TURN_RIGHT, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[17] = '{cpru_pkg::ACT_TILT_LEFT, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[18] = '{cpru_pkg::ACT_TILT_RIGHT, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[19] = '{ACT_UNUSED_LO, S_MAX, S_MIN, 1, 0, 0, 0, 0};
        // zero up vector, then turn about a zero axis
        dir_tab[20] = '{cpru_pkg::ACT_LOAD_UP, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[21] = '{cpru_pkg::ACT_TURN_LEFT, 0, 0, 0, 0, 0, 0, 0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults from reset, directed walk
        foreach (dir_tab[i])
        begin
            it.action = dir_tab[i].act;
            it.load_x = dir_tab[i].x;
            it.load_y = dir_tab[i].y;
            it.load_z = dir_tab[i].z;
            kf[0] = 64'(dir_tab[i].fx);
            kf[1] = 64'(dir_tab[i].fy);
            kf[2] = 64'(dir_tab[i].fz);
            send_cmd(it, dir_tab[i].known, kf);
        end
        drain();
        random_set(RAND_PER_SET);

        // top of the move, plane width and focal ranges
        set_regs(31'h7fffffff, 65536, 131072, 31'h7fffffff, 31'h7fffffff);
        random_set(RAND_PER_SET);

        // everything zero
        set_regs(0, 0, 0, 0, 0);
        random_set(RAND_PER_SET);

        // moderate values; receiver holds off long enough to back up the input
        set_regs($urandom_range(0, 1 << 20), $urandom_range(0, 65536),
                 $urandom_range(0, 131072), $urandom_range(0, 1 << 20),
                 $urandom_range(0, 1 << 18));
        hold_req = PRESSURE_HOLD;
        random_set(RAND_PER_SET);

        // full-width random data, masked by the register widths
        set_regs({$urandom} & 31'h7fffffff, {$urandom} & 31'h7fffffff,
                 {$urandom} & 31'h7fffffff, {$urandom} & 31'h7fffffff,
                 {$urandom} & 31'h7fffffff);
        random_set(RAND_PER_SET);

        // back to reset values, no idling on either side
        set_regs(6554, 1144, 10, 131072, 32768);
        quiet = 1'b1;
        random_set(RAND_PER_SET / 2);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
